### rtl/core/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared constants and round functions for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic       OP_ABSORB = 1'b0;
    localparam logic       OP_FINISH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       wr_byte;     // write byte into the buffer at wr_addr
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       comp_start;  // copy chaining words into working vars
        logic       round_en;    // run one round
        logic [6:0] round_idx;
        logic       comp_end;    // add working vars into chaining words
        logic       restart;     // load initial value
    } t_dp_cmd;

    function automatic logic [31:0] f_round(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20)      r = d ^ (b & (c ^ d));
        else if (t < 7'd40) r = b ^ c ^ d;
        else if (t < 7'd60) r = (b & c) | ((b | c) & d);
        else                r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] k_round(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)      r = K0;
        else if (t < 7'd40) r = K1;
        else if (t < 7'd60) r = K2;
        else                r = K3;
        return r;
    endfunction

endpackage

### rtl/core/sha1_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Block buffer, message schedule window, working variables and chaining words.
// ----------------------------------------------------------------------------
module sha1_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_dp_cmd i_cmd,
    input  logic [2:0]        i_word_sel,
    output logic [31:0]       o_word
);

    // The block buffer holds sixteen big-endian words; byte 0 of a word sits
    // in bits 31:24.
    logic [31:0] r_buf [16];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [31:0] w_new, n_tmp;
    logic [3:0]  t4;

    assign t4 = i_cmd.round_idx[3:0];

    always_comb begin
        if (i_cmd.round_idx < 7'd16) begin
            w_new = r_buf[t4];
        end else begin
            w_new = r_w[t4 - 4'd3] ^ r_w[t4 - 4'd8] ^ r_w[t4 - 4'd14] ^ r_w[t4];
            w_new = {w_new[30:0], w_new[31]};
        end
        n_tmp = {r_a[26:0], r_a[31:27]}
              + sha1_pkg::f_round(i_cmd.round_idx, r_b, r_c, r_d)
              + r_e + sha1_pkg::k_round(i_cmd.round_idx) + w_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_buf[i_cmd.wr_addr[5:2]][{~i_cmd.wr_addr[1:0], 3'b000} +: 8] <= i_cmd.wr_data;
        end
        if (i_cmd.comp_start) begin
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_w[t4] <= w_new;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= n_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h[0] <= sha1_pkg::IV0; r_h[1] <= sha1_pkg::IV1; r_h[2] <= sha1_pkg::IV2;
            r_h[3] <= sha1_pkg::IV3; r_h[4] <= sha1_pkg::IV4;
        end else if (i_cmd.comp_end) begin
            r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
        end
    end

    always_comb begin
        unique case (i_word_sel)
            3'd0:    o_word = r_h[0];
            3'd1:    o_word = r_h[1];
            3'd2:    o_word = r_h[2];
            3'd3:    o_word = r_h[3];
            default: o_word = r_h[4];
        endcase
    end

endmodule

### rtl/core/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte writes, padding, 80-round compressions and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_word_index,
    output logic              o_last_word,
    output sha1_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_ROUND, S_FOLD, S_PAD, S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [6:0]  r_round;
    logic        r_final;    // compression belongs to the end-of-message sequence
    logic        r_len_done; // current padding block carries the length
    logic [2:0]  r_widx;
    logic [63:0] bits;
    logic        acc;

    assign bits  = {r_count, 3'b000};
    assign acc   = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_word_index = r_widx;
    assign o_last_word  = (r_widx == 3'd4);

    always_comb begin
        o_cmd = '0;
        o_cmd.round_idx = r_round;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_addr = r_fill;
                    o_cmd.wr_data = (i_op == sha1_pkg::OP_ABSORB) ? i_data_byte
                                                                  : sha1_pkg::PAD_BYTE;
                end
            end
            S_PAD: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_addr = r_fill;
                if (r_len_done && r_fill >= 6'd56) begin
                    o_cmd.wr_data = bits[6'd63 - {r_fill[2:0], 3'b000} -: 8];
                end else begin
                    o_cmd.wr_data = 8'h00;
                end
            end
            S_INIT:  o_cmd.comp_start = 1'b1;
            S_ROUND: o_cmd.round_en = 1'b1;
            S_FOLD:  o_cmd.comp_end = 1'b1;
            S_OUT:   o_cmd.restart = i_ready && (r_widx == 3'd4);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_round    <= '0;
            r_final    <= 1'b0;
            r_len_done <= 1'b0;
            r_widx     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_fill <= r_fill + 6'd1;
                        if (i_op == sha1_pkg::OP_ABSORB) begin
                            r_count <= r_count + 61'd1;
                            r_final <= 1'b0;
                            if (r_fill == 6'd63) r_state <= S_INIT;
                        end else begin
                            r_final    <= 1'b1;
                            // Late padding needs one extra block of zeros first.
                            r_len_done <= (r_fill < 6'd56);
                            r_state    <= (r_fill == 6'd63) ? S_INIT : S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == 6'd63) r_state <= S_INIT;
                end
                S_INIT: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'd79) r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_widx <= '0;
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (r_len_done) begin
                        r_state <= S_OUT;
                    end else begin
                        r_len_done <= 1'b1;
                        r_state    <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_widx <= r_widx + 3'd1;
                        if (r_widx == 3'd4) begin
                            r_state <= S_IDLE;
                            r_fill  <= '0;
                            r_count <= '0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-wide SHA-1 engine: absorbs message bytes and emits a five-word digest.
// ----------------------------------------------------------------------------
// Each request carries one message byte (op 0) or an end-of-message mark
// (op 1). A byte is written into the block buffer; the 64th byte of a block
// also starts the compression (one load, 80 rounds at one round per cycle,
// one fold into the chaining words), during which no request is taken.
// An end-of-message request writes the padding one byte per cycle up to the
// end of the block, runs one or two compressions (two when 56 or more bytes
// were already in the block), then presents the five digest words, most
// significant first, one per output request. The block then reloads the
// SHA-1 initial value and is ready for the next message. No new byte is
// taken while the single shared round unit runs a compression.
module sha1_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha1_pkg::t_dp_cmd cmd;

    sha1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (cmd)
    );

    sha1_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_word_sel (o_word_index),
        .o_word     (o_digest_word)
    );

    // Input and output never handshake in the same cycle.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("input and output active together");

    // After the last digest word is taken, the block is ready again.
    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> o_ready)
        else $error("not ready after digest");

    // The word index only moves forward by one on an output transfer.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) |=>
        (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word index skipped");

endmodule
